>>> rtl/cpr_pkg.sv
// shared types and constants for the clock page replacement block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

    localparam int PAGES  = 16;
    localparam int PROCS  = 4;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int PID_W  = 2;
    localparam int ADDR_W = PID_W + IDX_W;
    localparam int DEPTH  = PROCS * PAGES;
    localparam int QDEPTH = 2;

    localparam logic [1:0] CMD_ACCESS = 2'd0;
    localparam logic [1:0] CMD_FAULT  = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        K_ACCESS,
        K_FAULT,
        K_FLUSH,
        K_BAD
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  pid;
        logic [15:0] page;
        logic [7:0]  frame;
        logic        wr;
    } item_t;

    typedef struct packed {
        logic [15:0] page;
        logic [7:0]  frame;
        logic        use_b;
        logic        mod_b;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } qctl_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_RD,
        B_CHK,
        B_SWP_RD,
        B_SWP_CHK,
        B_SH_RD,
        B_SH_WR,
        B_APPEND,
        B_FL_RD,
        B_FL_OUT
    } bstate_t;

endpackage

`default_nettype wire

>>> rtl/cpr_front.sv
// front end: takes requests, classifies them and queues them
// depends on cpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpr_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [1:0]      command,
    input  wire logic [1:0]      process_id,
    input  wire logic [15:0]     page_number,
    input  wire logic [7:0]      frame_id,
    input  wire logic            write_op,
    output logic                 busy,
    input  wire logic            q_pop,
    output cpr_pkg::qctl_t       q_stat,
    output cpr_pkg::item_t       q_item
);

    cpr_pkg::item_t q_mem_reg [cpr_pkg::QDEPTH];
    logic           rd_ptr_reg, rd_ptr_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push;
    cpr_pkg::item_t new_item;

    // classify the incoming request
    always_comb
    begin
        new_item.pid   = process_id;
        new_item.page  = page_number;
        new_item.frame = frame_id;
        new_item.wr    = write_op;
        case (command)
            cpr_pkg::CMD_ACCESS: new_item.kind = cpr_pkg::K_ACCESS;
            cpr_pkg::CMD_FAULT:  new_item.kind = cpr_pkg::K_FAULT;
            cpr_pkg::CMD_FLUSH:  new_item.kind = cpr_pkg::K_FLUSH;
            default:             new_item.kind = cpr_pkg::K_BAD;
        endcase
    end

    assign busy = (fill_reg == 2'(cpr_pkg::QDEPTH));
    assign push = start && !busy;

    // queue pointers
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign q_item       = q_mem_reg[rd_ptr_reg];
    assign q_stat.valid = (fill_reg != 2'd0);
    assign q_stat.pop   = q_pop;

    // pop only what is there
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> fill_reg != 2'd0)
        else $error("pop from empty queue");
    // fill never overruns
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'(cpr_pkg::QDEPTH))
        else $error("queue overrun");
    // a push into a non-full queue raises the fill unless popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("queue fill mismatch");

endmodule

`default_nettype wire

>>> rtl/cpr_back.sv
// back end: resident list memory and the lookup, sweep, shift and flush sequencer
// depends on cpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpr_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            mode,
    input  wire logic [4:0]      limit_cfg,
    input  wire cpr_pkg::qctl_t  q_stat,
    input  wire cpr_pkg::item_t  q_item,
    output logic                 q_pop,
    output logic                 done,
    output logic                 hit,
    output logic [7:0]           granted_frame,
    output logic                 evicted,
    output logic [15:0]          victim_page,
    output logic [7:0]           victim_frame,
    output logic                 victim_dirty,
    output logic                 last
);

    localparam int CW = cpr_pkg::CNT_W;
    localparam int IW = cpr_pkg::IDX_W;

    cpr_pkg::entry_t mem [cpr_pkg::DEPTH];
    cpr_pkg::entry_t rd_data_reg;

    cpr_pkg::bstate_t state_reg, state_next;
    cpr_pkg::item_t   item_reg, item_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    start_reg, start_next;
    logic             lap_reg, lap_next;
    logic [IW-1:0]    vic_reg, vic_next;
    logic [15:0]      vpage_reg, vpage_next;
    logic [7:0]       vframe_reg, vframe_next;
    logic             vdirty_reg, vdirty_next;
    logic [CW-1:0]    count_reg [cpr_pkg::PROCS];
    logic [IW-1:0]    ptr_reg [cpr_pkg::PROCS];
    logic [CW-1:0]    count_wr_val;
    logic [IW-1:0]    ptr_wr_val;
    logic             count_we, ptr_we;

    logic             ov_reg, ov_next;
    logic             hit_reg, hit_next;
    logic [7:0]       gf_reg, gf_next;
    logic             ev_reg, ev_next;
    logic [15:0]      vp_reg, vp_next;
    logic [7:0]       vf_reg, vf_next;
    logic             vd_reg, vd_next;
    logic             last_reg, last_next;

    logic                       we;
    logic [cpr_pkg::ADDR_W-1:0] waddr;
    cpr_pkg::entry_t            wdata;
    logic [IW-1:0]              rd_idx;
    logic [CW-1:0]              lim;
    logic [CW-1:0]              idx_inc;
    logic [CW-1:0]              nidx;
    logic                       pick;
    cpr_pkg::entry_t            d;

    // clamp the frame limit into one through PAGES
    always_comb
    begin
        if (limit_cfg == '0)
        begin
            lim = CW'(1);
        end
        else if (limit_cfg > CW'(cpr_pkg::PAGES))
        begin
            lim = CW'(cpr_pkg::PAGES);
        end
        else
        begin
            lim = limit_cfg;
        end
    end

    assign d       = rd_data_reg;
    assign idx_inc = idx_reg + CW'(1);
    assign nidx    = (idx_inc == n_reg) ? '0 : idx_inc;

    // victim test for the current pass
    always_comb
    begin
        if (mode)
        begin
            pick = !d.use_b;
        end
        else if (!lap_reg)
        begin
            pick = !d.use_b && !d.mod_b;
        end
        else
        begin
            pick = !d.use_b && d.mod_b;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        start_next   = start_reg;
        lap_next     = lap_reg;
        vic_next     = vic_reg;
        vpage_next   = vpage_reg;
        vframe_next  = vframe_reg;
        vdirty_next  = vdirty_reg;
        count_we     = 1'b0;
        count_wr_val = '0;
        ptr_we       = 1'b0;
        ptr_wr_val   = '0;
        we           = 1'b0;
        waddr        = {item_reg.pid, idx_reg[IW-1:0]};
        wdata        = d;
        rd_idx       = idx_reg[IW-1:0];
        q_pop        = 1'b0;
        ov_next      = 1'b0;
        hit_next     = 1'b0;
        gf_next      = '0;
        ev_next      = 1'b0;
        vp_next      = '0;
        vf_next      = '0;
        vd_next      = 1'b0;
        last_next    = 1'b0;
        case (state_reg)
            cpr_pkg::B_IDLE:
            begin
                if (q_stat.valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    n_next    = count_reg[q_item.pid];
                    idx_next  = '0;
                    case (q_item.kind)
                        cpr_pkg::K_ACCESS, cpr_pkg::K_FAULT:
                        begin
                            state_next = cpr_pkg::B_RD;
                        end
                        cpr_pkg::K_FLUSH:
                        begin
                            if (count_reg[q_item.pid] == '0)
                            begin
                                ov_next   = 1'b1;
                                last_next = 1'b1;
                                ptr_we    = 1'b1;
                            end
                            else
                            begin
                                state_next = cpr_pkg::B_FL_RD;
                            end
                        end
                        default:
                        begin
                            ov_next   = 1'b1;
                            last_next = 1'b1;
                        end
                    endcase
                end
            end
            cpr_pkg::B_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    // scan found nothing
                    if (item_reg.kind == cpr_pkg::K_ACCESS)
                    begin
                        ov_next    = 1'b1;
                        last_next  = 1'b1;
                        state_next = cpr_pkg::B_IDLE;
                    end
                    else if (n_reg < lim)
                    begin
                        we           = 1'b1;
                        waddr        = {item_reg.pid, n_reg[IW-1:0]};
                        wdata        = '{page: item_reg.page, frame: item_reg.frame,
                                         use_b: 1'b0, mod_b: 1'b0};
                        count_we     = 1'b1;
                        count_wr_val = n_reg + CW'(1);
                        ov_next      = 1'b1;
                        gf_next      = item_reg.frame;
                        last_next    = 1'b1;
                        state_next   = cpr_pkg::B_IDLE;
                    end
                    else
                    begin
                        if ({1'b0, ptr_reg[item_reg.pid]} < n_reg)
                        begin
                            start_next = ptr_reg[item_reg.pid];
                        end
                        else
                        begin
                            start_next = '0;
                        end
                        idx_next   = {1'b0, start_next};
                        lap_next   = 1'b0;
                        state_next = cpr_pkg::B_SWP_RD;
                    end
                end
                else
                begin
                    state_next = cpr_pkg::B_CHK;
                end
            end
            cpr_pkg::B_CHK:
            begin
                if (item_reg.kind == cpr_pkg::K_ACCESS && d.frame == item_reg.frame)
                begin
                    we         = 1'b1;
                    wdata      = '{page: d.page, frame: d.frame, use_b: 1'b1,
                                   mod_b: d.mod_b | item_reg.wr};
                    ov_next    = 1'b1;
                    hit_next   = 1'b1;
                    last_next  = 1'b1;
                    state_next = cpr_pkg::B_IDLE;
                end
                else if (item_reg.kind == cpr_pkg::K_FAULT && d.page == item_reg.page)
                begin
                    ov_next    = 1'b1;
                    hit_next   = 1'b1;
                    gf_next    = d.frame;
                    last_next  = 1'b1;
                    state_next = cpr_pkg::B_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = cpr_pkg::B_RD;
                end
            end
            cpr_pkg::B_SWP_RD:
            begin
                state_next = cpr_pkg::B_SWP_CHK;
            end
            cpr_pkg::B_SWP_CHK:
            begin
                if (pick)
                begin
                    vic_next    = idx_reg[IW-1:0];
                    vpage_next  = d.page;
                    vframe_next = d.frame;
                    vdirty_next = d.mod_b;
                    if (idx_inc < n_reg)
                    begin
                        state_next = cpr_pkg::B_SH_RD;
                    end
                    else
                    begin
                        state_next = cpr_pkg::B_APPEND;
                    end
                end
                else
                begin
                    // second chance: clear use on clock, or on the second and fourth passes
                    if (mode || lap_reg)
                    begin
                        we    = 1'b1;
                        wdata = '{page: d.page, frame: d.frame, use_b: 1'b0,
                                  mod_b: d.mod_b};
                    end
                    if (nidx == {1'b0, start_reg})
                    begin
                        lap_next = ~lap_reg;
                    end
                    idx_next   = nidx;
                    state_next = cpr_pkg::B_SWP_RD;
                end
            end
            cpr_pkg::B_SH_RD:
            begin
                rd_idx     = idx_inc[IW-1:0];
                state_next = cpr_pkg::B_SH_WR;
            end
            cpr_pkg::B_SH_WR:
            begin
                we       = 1'b1;
                idx_next = idx_inc;
                if (idx_inc + CW'(1) < n_reg)
                begin
                    state_next = cpr_pkg::B_SH_RD;
                end
                else
                begin
                    state_next = cpr_pkg::B_APPEND;
                end
            end
            cpr_pkg::B_APPEND:
            begin
                we     = 1'b1;
                waddr  = {item_reg.pid, IW'(n_reg - CW'(1))};
                wdata  = '{page: item_reg.page, frame: vframe_reg, use_b: 1'b0,
                           mod_b: 1'b0};
                ptr_we = 1'b1;
                if (n_reg == CW'(1) || {1'b0, vic_reg} == n_reg - CW'(1))
                begin
                    ptr_wr_val = '0;
                end
                else
                begin
                    ptr_wr_val = vic_reg;
                end
                ov_next    = 1'b1;
                gf_next    = vframe_reg;
                ev_next    = 1'b1;
                vp_next    = vpage_reg;
                vf_next    = vframe_reg;
                vd_next    = vdirty_reg;
                last_next  = 1'b1;
                state_next = cpr_pkg::B_IDLE;
            end
            cpr_pkg::B_FL_RD:
            begin
                state_next = cpr_pkg::B_FL_OUT;
            end
            cpr_pkg::B_FL_OUT:
            begin
                ov_next = 1'b1;
                ev_next = 1'b1;
                vp_next = d.page;
                vf_next = d.frame;
                vd_next = d.mod_b;
                if (idx_inc == n_reg)
                begin
                    last_next    = 1'b1;
                    count_we     = 1'b1;
                    count_wr_val = '0;
                    ptr_we       = 1'b1;
                    state_next   = cpr_pkg::B_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = cpr_pkg::B_FL_RD;
                end
            end
            default:
            begin
                state_next = cpr_pkg::B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpr_pkg::B_IDLE;
            ov_reg    <= 1'b0;
            for (int p = 0; p < cpr_pkg::PROCS; p++)
            begin
                count_reg[p] <= '0;
                ptr_reg[p]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (count_we)
            begin
                count_reg[item_reg.pid] <= count_wr_val;
            end
            if (ptr_we)
            begin
                ptr_reg[q_pop ? q_item.pid : item_reg.pid] <= ptr_wr_val;
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        start_reg  <= start_next;
        lap_reg    <= lap_next;
        vic_reg    <= vic_next;
        vpage_reg  <= vpage_next;
        vframe_reg <= vframe_next;
        vdirty_reg <= vdirty_next;
        hit_reg    <= hit_next;
        gf_reg     <= gf_next;
        ev_reg     <= ev_next;
        vp_reg     <= vp_next;
        vf_reg     <= vf_next;
        vd_reg     <= vd_next;
        last_reg   <= last_next;
    end

    // resident list memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[{item_reg.pid, rd_idx}];
    end

    assign done          = ov_reg;
    assign hit           = hit_reg;
    assign granted_frame = gf_reg;
    assign evicted       = ev_reg;
    assign victim_page   = vp_reg;
    assign victim_frame  = vf_reg;
    assign victim_dirty  = vd_reg;
    assign last          = last_reg;

    // resident count of the request being worked on stays within the list size
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != cpr_pkg::B_IDLE |-> count_reg[item_reg.pid] <= CW'(cpr_pkg::PAGES))
        else $error("resident count overflow");
    // the sweep only visits live entries
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cpr_pkg::B_SWP_CHK |-> idx_reg < n_reg)
        else $error("sweep index past count");
    // a shift step always has a successor entry to copy
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cpr_pkg::B_SH_RD |-> idx_inc < n_reg)
        else $error("shift past end of list");
    // a new request is only taken while no result is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == cpr_pkg::B_IDLE)
        else $error("pop while busy");

endmodule

`default_nettype wire

>>> rtl/clock_page_replacement.sv
// top level of the clock page replacement block: register port, front and back
// depends on cpr_pkg, cpr_front, cpr_back
//
// channel   direction  handshake                 payload
// request   in         start && !busy            command process_id page_number
//                                                frame_id write_op
// result    out        done strobe, one cycle    hit granted_frame evicted victim_page
//                                                victim_frame victim_dirty last
// config    in         psel penable pwrite       paddr pwdata prdata
//
// an access or a resident fault reads and checks the list one entry at a time
// a replacement adds a sweep from the hand (up to four laps) and a shift of each later entry
// a flush gives one result per resident entry; every step uses the single memory read port
// reset empties every list at once; memory contents are not cleared
// up to two requests wait in the queue; busy rises when it is full
`timescale 1ns / 1ps
`default_nettype none

module clock_page_replacement (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [1:0]  process_id,
    input  wire logic [15:0] page_number,
    input  wire logic [7:0]  frame_id,
    input  wire logic        write_op,
    output logic             done,
    output logic             hit,
    output logic [7:0]       granted_frame,
    output logic             evicted,
    output logic [15:0]      victim_page,
    output logic [7:0]       victim_frame,
    output logic             victim_dirty,
    output logic             last
);

    logic           mode_reg;
    logic [4:0]     limit_reg;
    logic           q_pop;
    cpr_pkg::qctl_t q_stat;
    cpr_pkg::item_t q_item;

    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            limit_reg <= 5'd4;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == cpr_pkg::REG_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            else
            begin
                limit_reg <= pwdata[4:0];
            end
        end
    end

    // register read back
    always_comb
    begin
        if (paddr[2] == cpr_pkg::REG_LIMIT)
        begin
            prdata = {27'd0, limit_reg};
        end
        else
        begin
            prdata = {31'd0, mode_reg};
        end
    end

    cpr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .process_id   (process_id),
        .page_number  (page_number),
        .frame_id     (frame_id),
        .write_op     (write_op),
        .busy         (busy),
        .q_pop        (q_pop),
        .q_stat       (q_stat),
        .q_item       (q_item)
    );

    cpr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .limit_cfg     (limit_reg),
        .q_stat        (q_stat),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .done          (done),
        .hit           (hit),
        .granted_frame (granted_frame),
        .evicted       (evicted),
        .victim_page   (victim_page),
        .victim_frame  (victim_frame),
        .victim_dirty  (victim_dirty),
        .last          (last)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_clock_page_replacement.sv
// testbench for clock_page_replacement: directed and random requests, scoreboard check
// depends on cpr_pkg and the clock_page_replacement rtl
`timescale 1ns / 1ps

module tb_clock_page_replacement;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int FLUSH_SETTLE = 120;
    localparam int QUIET_LIMIT  = 6000;

    typedef struct packed {
        logic        hit;
        logic [7:0]  granted_frame;
        logic        evicted;
        logic [15:0] victim_page;
        logic [7:0]  victim_frame;
        logic        victim_dirty;
        logic        last;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [1:0]  process_id;
    logic [15:0] page_number;
    logic [7:0]  frame_id;
    logic        write_op;
    logic        done;
    logic        hit;
    logic [7:0]  granted_frame;
    logic        evicted;
    logic [15:0] victim_page;
    logic [7:0]  victim_frame;
    logic        victim_dirty;
    logic        last;

    // predictor copy of the block state
    logic [15:0] res_page [cpr_pkg::PROCS][cpr_pkg::PAGES];
    logic [7:0]  res_frame[cpr_pkg::PROCS][cpr_pkg::PAGES];
    logic        res_use  [cpr_pkg::PROCS][cpr_pkg::PAGES];
    logic        res_mod  [cpr_pkg::PROCS][cpr_pkg::PAGES];
    int          res_count[cpr_pkg::PROCS];
    int          hand     [cpr_pkg::PROCS];
    logic        mode_plain;
    logic [4:0]  limit_reg;

    outcome_t    pending_outcomes[$];
    int          errors;
    int          quiet_cycles;
    int          idle_pct;

    clock_page_replacement uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .command(command), .process_id(process_id),
        .page_number(page_number), .frame_id(frame_id), .write_op(write_op),
        .done(done), .hit(hit), .granted_frame(granted_frame), .evicted(evicted),
        .victim_page(victim_page), .victim_frame(victim_frame),
        .victim_dirty(victim_dirty), .last(last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic outcome_t mk(logic h, logic [7:0] g, logic e, logic [15:0] vp,
                                    logic [7:0] vf, logic vd, logic l);
        outcome_t o;
        o = '{h, g, e, vp, vf, vd, l};
        return o;
    endfunction

    // victim search from the clock hand, clearing use bits as the pass rules say
    function automatic int sweep_victim(int p);
        int n;
        int first;
        int idx;
        int lap;
        logic pass_one;
        logic pick;
        n = res_count[p];
        first = (hand[p] < n) ? hand[p] : 0;
        idx = first;
        lap = 0;
        for (int s = 0; s < 4 * cpr_pkg::PAGES; s++)
        begin
            pass_one = (lap % 2) == 0;
            if (!mode_plain)
                pick = pass_one ? (!res_use[p][idx] && !res_mod[p][idx])
                                : (!res_use[p][idx] && res_mod[p][idx]);
            else
                pick = !res_use[p][idx];
            if (pick)
                return idx;
            if (mode_plain || !pass_one)
                res_use[p][idx] = 1'b0;
            idx = (idx + 1) % n;
            if (idx == first)
                lap++;
        end
        return idx;
    endfunction

    // expected results of one accepted request, pushed in order
    task automatic predict_request(logic [1:0] cmd, int p, logic [15:0] pg,
                                   logic [7:0] fr, logic wr);
        int n;
        int lim;
        int v;
        logic [15:0] vp;
        logic [7:0]  vf;
        logic        vd;
        n = res_count[p];
        if (cmd == cpr_pkg::CMD_ACCESS)
        begin
            for (int i = 0; i < n; i++)
                if (res_frame[p][i] == fr)
                begin
                    res_use[p][i] = 1'b1;
                    if (wr)
                        res_mod[p][i] = 1'b1;
                    pending_outcomes.push_back(mk(1, 0, 0, 0, 0, 0, 1));
                    return;
                end
            pending_outcomes.push_back(mk(0, 0, 0, 0, 0, 0, 1));
        end
        else if (cmd == cpr_pkg::CMD_FAULT)
        begin
            lim = limit_reg;
            if (lim < 1)
                lim = 1;
            if (lim > cpr_pkg::PAGES)
                lim = cpr_pkg::PAGES;
            for (int i = 0; i < n; i++)
                if (res_page[p][i] == pg)
                begin
                    pending_outcomes.push_back(mk(1, res_frame[p][i], 0, 0, 0, 0, 1));
                    return;
                end
            if (n < lim)
            begin
                res_page[p][n] = pg;
                res_frame[p][n] = fr;
                res_use[p][n] = 1'b0;
                res_mod[p][n] = 1'b0;
                res_count[p] = n + 1;
                pending_outcomes.push_back(mk(0, fr, 0, 0, 0, 0, 1));
            end
            else
            begin
                v = sweep_victim(p);
                vp = res_page[p][v];
                vf = res_frame[p][v];
                vd = res_mod[p][v];
                for (int i = v; i + 1 < n; i++)
                begin
                    res_page[p][i]  = res_page[p][i + 1];
                    res_frame[p][i] = res_frame[p][i + 1];
                    res_use[p][i]   = res_use[p][i + 1];
                    res_mod[p][i]   = res_mod[p][i + 1];
                end
                hand[p] = (n - 1 > 0) ? v % (n - 1) : 0;
                res_page[p][n - 1] = pg;
                res_frame[p][n - 1] = vf;
                res_use[p][n - 1] = 1'b0;
                res_mod[p][n - 1] = 1'b0;
                pending_outcomes.push_back(mk(0, vf, 1, vp, vf, vd, 1));
            end
        end
        else if (cmd == cpr_pkg::CMD_FLUSH)
        begin
            if (n == 0)
                pending_outcomes.push_back(mk(0, 0, 0, 0, 0, 0, 1));
            for (int i = 0; i < n; i++)
                pending_outcomes.push_back(mk(0, 0, 1, res_page[p][i], res_frame[p][i],
                                              res_mod[p][i], i + 1 == n));
            res_count[p] = 0;
            hand[p] = 0;
        end
        else
            pending_outcomes.push_back(mk(0, 0, 0, 0, 0, 0, 1));
    endtask

    // send one request, wait for acceptance, then maybe idle
    task automatic send_request(logic [1:0] cmd, logic [1:0] p, logic [15:0] pg,
                                logic [7:0] fr, logic wr);
        start <= 1'b1;
        command <= cmd;
        process_id <= p;
        page_number <= pg;
        frame_id <= fr;
        write_op <= wr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(cmd, p, pg, fr, wr);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // drain all results, then let the block settle before touching registers
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (FLUSH_SETTLE) @(posedge clk);
    endtask

    // apb write: setup then access cycle
    task automatic write_register(logic idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == cpr_pkg::REG_MODE)
            mode_plain = value[0];
        else
            limit_reg = value[4:0];
    endtask

    task automatic configure(logic plain, logic [4:0] lim);
        wait_drained();
        write_register(cpr_pkg::REG_MODE, {31'd0, plain});
        write_register(cpr_pkg::REG_LIMIT, {27'd0, lim});
    endtask

    // one random request, biased toward hits on resident frames and pages
    task automatic random_request();
        int r;
        int p;
        logic [1:0]  cmd;
        logic [15:0] pg;
        logic [7:0]  fr;
        r = $urandom_range(99);
        p = $urandom_range(cpr_pkg::PROCS - 1);
        pg = ($urandom_range(9) < 8) ? 16'($urandom_range(23)) : 16'($urandom);
        fr = 8'($urandom);
        if (r < 58)
        begin
            cmd = cpr_pkg::CMD_ACCESS;
            if (res_count[p] > 0 && $urandom_range(3) != 0)
                fr = res_frame[p][$urandom_range(res_count[p] - 1)];
        end
        else if (r < 92)
            cmd = cpr_pkg::CMD_FAULT;
        else if (r < 97)
            cmd = cpr_pkg::CMD_FLUSH;
        else
            cmd = CMD_UNKNOWN;
        send_request(cmd, 2'(p), pg, fr, 1'($urandom));
    endtask

    // edge values, every command, resident fault, replacement, empty flush
    task automatic test_directed();
        idle_pct = 0;
        send_request(cpr_pkg::CMD_ACCESS, 0, 16'h0000, 8'd0, 0);
        send_request(cpr_pkg::CMD_FLUSH, 1, 16'h0000, 8'd0, 0);
        send_request(cpr_pkg::CMD_FAULT, 0, 16'h0000, 8'd0, 0);
        send_request(cpr_pkg::CMD_FAULT, 0, 16'hFFFF, 8'd255, 0);
        send_request(cpr_pkg::CMD_FAULT, 0, 16'h5A5A, 8'd85, 0);
        send_request(cpr_pkg::CMD_FAULT, 0, 16'hA5A5, 8'd170, 0);
        send_request(cpr_pkg::CMD_ACCESS, 0, 16'h0000, 8'd255, 1);
        send_request(cpr_pkg::CMD_ACCESS, 0, 16'h0000, 8'd0, 0);
        send_request(cpr_pkg::CMD_ACCESS, 0, 16'hFFFF, 8'd17, 1);
        send_request(cpr_pkg::CMD_FAULT, 0, 16'hFFFF, 8'd3, 1);
        send_request(cpr_pkg::CMD_FAULT, 0, 16'h1234, 8'd9, 0);
        send_request(cpr_pkg::CMD_FAULT, 0, 16'h4321, 8'd10, 0);
        send_request(cpr_pkg::CMD_ACCESS, 0, 16'h0000, 8'd170, 1);
        send_request(cpr_pkg::CMD_FAULT, 0, 16'h7777, 8'd11, 0);
        send_request(cpr_pkg::CMD_FAULT, 3, 16'hFFFF, 8'd255, 1);
        send_request(CMD_UNKNOWN, 3, 16'hFFFF, 8'd255, 1);
        send_request(CMD_UNKNOWN, 0, 16'h0000, 8'd0, 0);
        send_request(cpr_pkg::CMD_FLUSH, 0, 16'h0000, 8'd0, 0);
        send_request(cpr_pkg::CMD_FLUSH, 3, 16'hFFFF, 8'd255, 1);
        send_request(cpr_pkg::CMD_FLUSH, 0, 16'h0000, 8'd0, 0);
    endtask

    task automatic test_random_phase(logic plain, logic [4:0] lim, int idle, int count);
        configure(plain, lim);
        idle_pct = idle;
        repeat (count) random_request();
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && done)
        begin
            got = '{hit, granted_frame, evicted, victim_page, victim_frame,
                    victim_dirty, last};
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.hit !== want.hit || got.granted_frame !== want.granted_frame ||
                    got.evicted !== want.evicted || got.victim_page !== want.victim_page ||
                    got.victim_frame !== want.victim_frame ||
                    got.victim_dirty !== want.victim_dirty || got.last !== want.last)
                begin
                    $display("%0t mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        command = cpr_pkg::CMD_ACCESS;
        process_id = '0;
        page_number = '0;
        frame_id = '0;
        write_op = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        mode_plain = 1'b0;
        limit_reg = 5'd4;
        for (int p = 0; p < cpr_pkg::PROCS; p++)
        begin
            res_count[p] = 0;
            hand[p] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(1'b0, 5'd4, 0, 66);
        test_random_phase(1'b1, 5'd1, 62, 66);
        test_random_phase(1'b0, 5'd16, 36, 66);
        test_random_phase(1'b1, 5'd31, 0, 66);
        test_random_phase(1'b0, 5'd0, 62, 66);

        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
